FILE: rtl/tqr_pkg.sv
// Shared types and constants for the temperature reading qualifier.
// Used by the decode, median and top-level modules; no dependencies.
package tqr_pkg;

    localparam int unsigned RAW_W   = 16;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned FAIL_W  = 8;
    localparam int unsigned OKL_W   = 2;
    localparam int unsigned GOOD_W  = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned RAW_SHIFT  = 3;

    localparam logic signed [TEMP_W-1:0] REJECT_HOT  = 16'sd850;
    localparam logic signed [TEMP_W-1:0] REJECT_COLD = 16'sd0;

    localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST = 8'd60;
    localparam logic [OKL_W-1:0]  OK_LIMIT_RST   = 2'd2;
    localparam logic [OKL_W-1:0]  OK_LIMIT_MAX   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAIL_LIMIT = 2'd0,
        CFG_OK_LIMIT   = 2'd1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_READ_FAIL = 2'd1,
        ST_REJECTED  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [TEMP_W-1:0] value;
        logic                     reject;
    } t_decode;

endpackage

FILE: rtl/temperature_reading_qualifier_unit.sv
// Temperature reading qualifier: one result per read attempt.
// Each request passes through the input register and then the result register, from
// which its result is taken.
// Throughput: one request per cycle while i_stall is low; qualifier state is updated
// as a request leaves the input register, so the next one sees it without a bubble.
// Reset (synchronous, active low): counters, window, held value and fault flag clear,
// fail_limit returns to 60 and ok_limit to 2; both registers are empty.
module temperature_reading_qualifier_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // request channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_read_ok,
    input  logic signed [tqr_pkg::RAW_W-1:0]       i_raw_word,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_status,
    output logic signed [tqr_pkg::TEMP_W-1:0]      o_temperature,
    output logic                                   o_sensor_fault,
    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tqr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [tqr_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes are always taken; indexes past
    // the register list are dropped.
    // ---------------------------------------------------------------
    logic [tqr_pkg::FAIL_W-1:0] r_fail_limit;
    logic [tqr_pkg::OKL_W-1:0]  r_ok_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_limit <= tqr_pkg::FAIL_LIMIT_RST;
            r_ok_limit   <= tqr_pkg::OK_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tqr_pkg::CFG_FAIL_LIMIT: r_fail_limit <= i_cfg_data;
                tqr_pkg::CFG_OK_LIMIT:   r_ok_limit   <= i_cfg_data[tqr_pkg::OKL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake. The input register advances whenever the result
    // register is empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_s1_read_ok;
    logic signed [tqr_pkg::RAW_W-1:0] r_s1_raw;
    logic r_out_valid;
    logic s1_move;
    logic s1_load;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign s1_load = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // hold the request payload while stalled
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_read_ok <= i_read_ok;
            r_s1_raw     <= i_raw_word;
        end
    end

    // ---------------------------------------------------------------
    // Decode and median of the shifted window.
    // ---------------------------------------------------------------
    tqr_pkg::t_decode w_dec;

    tqr_decode u_decode (
        .i_raw_word (r_s1_raw),
        .o_dec      (w_dec)
    );

    logic [tqr_pkg::FAIL_W-1:0]           r_fail_count;
    logic [tqr_pkg::GOOD_W-1:0]           r_good_count;
    logic signed [tqr_pkg::TEMP_W-1:0]    r_win [3];
    logic signed [tqr_pkg::TEMP_W-1:0]    r_held;
    logic                                 r_fault_flag;

    logic signed [tqr_pkg::TEMP_W-1:0]    w_mid;

    // median of the window as it stands after the shift: win1, win2, new value
    tqr_median u_median (
        .i_a   (r_win[1]),
        .i_b   (r_win[2]),
        .i_c   (w_dec.value),
        .o_mid (w_mid)
    );

    // ---------------------------------------------------------------
    // Qualifier state update.
    // ---------------------------------------------------------------
    logic [tqr_pkg::FAIL_W-1:0]           n_fail_count;
    logic [tqr_pkg::GOOD_W-1:0]           n_good_count;
    logic signed [tqr_pkg::TEMP_W-1:0]    n_win [3];
    logic signed [tqr_pkg::TEMP_W-1:0]    n_held;
    logic                                 n_fault_flag;
    tqr_pkg::t_status                     n_status;

    logic                                 w_fail;
    logic [tqr_pkg::OKL_W-1:0]            w_limit;
    logic [tqr_pkg::FAIL_W-1:0]           w_fail_inc;

    assign w_fail     = !r_s1_read_ok || w_dec.reject;
    // clamp ok_limit so the window is never indexed past its depth
    assign w_limit    = (r_ok_limit > tqr_pkg::OK_LIMIT_MAX) ? tqr_pkg::OK_LIMIT_MAX : r_ok_limit;
    assign w_fail_inc = r_fail_count + 1'b1;

    always_comb begin
        n_fail_count = r_fail_count;
        n_good_count = r_good_count;
        n_win        = r_win;
        n_held       = r_held;
        n_fault_flag = r_fault_flag;
        n_status     = tqr_pkg::ST_ACCEPTED;
        if (w_fail) begin
            n_status     = r_s1_read_ok ? tqr_pkg::ST_REJECTED : tqr_pkg::ST_READ_FAIL;
            n_good_count = '0;
            // counter wraps at its width; at limit 255 the flag is never raised
            if (w_fail_inc > r_fail_limit) begin
                n_fail_count = '0;
                n_fault_flag = 1'b1;
            end else begin
                n_fail_count = w_fail_inc;
            end
        end else begin
            n_fault_flag = 1'b0;
            if (r_good_count > w_limit) begin
                // steady state: shift in and take the median
                n_fail_count = '0;
                n_win[0]     = r_win[1];
                n_win[1]     = r_win[2];
                n_win[2]     = w_dec.value;
                n_held       = w_mid;
            end else begin
                // fill phase: store in turn and pass through
                case (r_good_count)
                    2'd0:    n_win[0] = w_dec.value;
                    2'd1:    n_win[1] = w_dec.value;
                    default: n_win[2] = w_dec.value;
                endcase
                n_held       = w_dec.value;
                n_good_count = r_good_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_count <= '0;
            r_good_count <= '0;
            r_win[0]     <= '0;
            r_win[1]     <= '0;
            r_win[2]     <= '0;
            r_held       <= '0;
            r_fault_flag <= 1'b0;
        end else if (s1_move) begin
            r_fail_count <= n_fail_count;
            r_good_count <= n_good_count;
            r_win        <= n_win;
            r_held       <= n_held;
            r_fault_flag <= n_fault_flag;
        end
    end

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    tqr_pkg::t_status                  r_out_status;
    logic signed [tqr_pkg::TEMP_W-1:0] r_out_temp;
    logic                              r_out_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_status <= n_status;
            r_out_temp   <= n_held;
            r_out_fault  <= n_fault_flag;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_temperature  = r_out_temp;
    assign o_sensor_fault = r_out_fault;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a good reading always clears the fault flag
    a_good_clears_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !w_fail) |=> !r_fault_flag)
        else $error("fault flag still set after a good reading");

    // the fault flag is raised only by a failed request
    a_fault_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fault_flag) |-> $past(s1_move && w_fail))
        else $error("fault flag raised without a failed request");

    // a request held in the input register is never overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1_raw)))
        else $error("pending request lost from input register");

    // a pending result is not replaced while the consumer stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !s1_move)
        else $error("result register overwritten while stalled");

endmodule

FILE: rtl/tqr_decode.sv
// Raw scratchpad word to tenths of a degree, plus the 0 / 850 rejection test.
// Depends on tqr_pkg.
module tqr_decode (
    input  logic signed [tqr_pkg::RAW_W-1:0] i_raw_word,
    output tqr_pkg::t_decode                 o_dec
);

    logic signed [tqr_pkg::TEMP_W-1:0] w_q;
    logic signed [tqr_pkg::TEMP_W-1:0] w_val;

    // floor(raw / 8) times 5, done as q*4 + q; range stays inside 16 bits
    assign w_q   = i_raw_word >>> tqr_pkg::RAW_SHIFT;
    assign w_val = (w_q <<< 2) + w_q;

    assign o_dec.value  = w_val;
    assign o_dec.reject = (w_val == tqr_pkg::REJECT_COLD) || (w_val == tqr_pkg::REJECT_HOT);

endmodule

FILE: rtl/tqr_median.sv
// Median of three signed samples.
// Depends on tqr_pkg.
module tqr_median (
    input  logic signed [tqr_pkg::TEMP_W-1:0] i_a,
    input  logic signed [tqr_pkg::TEMP_W-1:0] i_b,
    input  logic signed [tqr_pkg::TEMP_W-1:0] i_c,
    output logic signed [tqr_pkg::TEMP_W-1:0] o_mid
);

    logic signed [tqr_pkg::TEMP_W-1:0] w_lo;
    logic signed [tqr_pkg::TEMP_W-1:0] w_hi;

    assign w_lo = (i_a < i_b) ? i_a : i_b;
    assign w_hi = (i_a < i_b) ? i_b : i_a;

    always_comb begin
        if (i_c <= w_lo) begin
            o_mid = w_lo;
        end else if (i_c >= w_hi) begin
            o_mid = w_hi;
        end else begin
            o_mid = i_c;
        end
    end

endmodule

FILE: bench/temperature_reading_qualifier_unit_test.sv
// Self-checking bench for temperature_reading_qualifier_unit: queued read attempts,
// a bit-accurate qualifier predictor and a result checker on the output channel.
// Depends on tqr_pkg and the unit itself, which brings in tqr_decode and tqr_median.
module temperature_reading_qualifier_unit_test;

    // Longest legal quiet stretch is the long receiver hold plus one idle burst
    // on each side; take that many times over.
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned LONG_HOLD    = 90;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        logic                              read_ok;
        logic signed [tqr_pkg::RAW_W-1:0]  raw;
    } t_reading;

    typedef struct {
        tqr_pkg::t_status                  status;
        logic signed [tqr_pkg::TEMP_W-1:0] temp;
        logic                              fault;
    } t_qual_result;

    // DUT ports; the inputs are known from time zero
    logic                              i_clk          = 1'b0;
    logic                              i_rst_n        = 1'b0;
    logic                              i_valid        = 1'b0;
    logic                              o_stall;
    logic                              i_read_ok      = 1'b0;
    logic signed [tqr_pkg::RAW_W-1:0]  i_raw_word     = '0;
    logic                              o_valid;
    logic                              i_stall        = 1'b0;
    logic [1:0]                        o_status;
    logic signed [tqr_pkg::TEMP_W-1:0] o_temperature;
    logic                              o_sensor_fault;
    logic                              i_cfg_valid    = 1'b0;
    logic                              o_cfg_ready;
    logic [tqr_pkg::CFG_IDX_W-1:0]     i_cfg_index    = '0;
    logic [tqr_pkg::CFG_DATA_W-1:0]    i_cfg_data     = '0;

    temperature_reading_qualifier_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_read_ok      (i_read_ok),
        .i_raw_word     (i_raw_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_temperature  (o_temperature),
        .o_sensor_fault (o_sensor_fault),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stimulus and bookkeeping
    t_reading     reading_queue[$];
    t_qual_result predicted_results[$];
    int unsigned  items_queued  = 0;
    int unsigned  results_seen  = 0;
    int unsigned  err_count     = 0;
    int unsigned  n_median      = 0;
    int unsigned  n_fault_rise  = 0;
    int unsigned  n_cfg_writes  = 0;
    logic         req_taken     = 1'b0;

    // Idling controls, owned by the initial block
    bit           tx_idle_on    = 1'b1;
    bit           rx_idle_on    = 1'b1;
    int unsigned  hold_asks     = 0;

    // Private counters of the driver, the receiver and the watchdog
    int unsigned  tx_gap        = 0;
    int unsigned  rx_burst      = 0;
    int unsigned  rx_hold       = 0;
    int unsigned  hold_served   = 0;
    int unsigned  quiet_cycles  = 0;

    // Qualifier model: configuration and state as the unit holds them
    logic [tqr_pkg::FAIL_W-1:0]        cfg_fail_limit = tqr_pkg::FAIL_LIMIT_RST;
    logic [tqr_pkg::OKL_W-1:0]         cfg_ok_limit   = tqr_pkg::OK_LIMIT_RST;
    logic [tqr_pkg::FAIL_W-1:0]        fail_cnt       = '0;
    logic [tqr_pkg::GOOD_W-1:0]        good_cnt       = '0;
    logic signed [tqr_pkg::TEMP_W-1:0] win_hist [3]   = '{default: '0};
    logic signed [tqr_pkg::TEMP_W-1:0] held_temp      = '0;
    logic                              fault_now      = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        err_count++;
    endtask

    function automatic logic signed [tqr_pkg::TEMP_W-1:0] median3(
        input logic signed [tqr_pkg::TEMP_W-1:0] a,
        input logic signed [tqr_pkg::TEMP_W-1:0] b,
        input logic signed [tqr_pkg::TEMP_W-1:0] c
    );
        logic signed [tqr_pkg::TEMP_W-1:0] lo;
        logic signed [tqr_pkg::TEMP_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    // Advance the model by one read attempt and return the result it causes.
    function automatic t_qual_result qualify_reading(input t_reading r);
        t_qual_result                     res;
        logic signed [tqr_pkg::RAW_W-1:0] shifted;
        int                               scaled;
        logic [tqr_pkg::OKL_W-1:0]        lim;
        logic                             was_fault;
        shifted   = r.raw >>> tqr_pkg::RAW_SHIFT;
        scaled    = int'(shifted) * 5;
        lim       = (cfg_ok_limit > tqr_pkg::OK_LIMIT_MAX) ? tqr_pkg::OK_LIMIT_MAX
                                                           : cfg_ok_limit;
        was_fault = fault_now;
        if (!r.read_ok || scaled == tqr_pkg::REJECT_COLD || scaled == tqr_pkg::REJECT_HOT) begin
            res.status = r.read_ok ? tqr_pkg::ST_REJECTED : tqr_pkg::ST_READ_FAIL;
            good_cnt   = '0;
            fail_cnt   = fail_cnt + 1'b1;
            // a limit of 255 never trips: the counter wraps before exceeding it
            if (fail_cnt > cfg_fail_limit) begin
                fail_cnt  = '0;
                fault_now = 1'b1;
            end
        end else begin
            res.status = tqr_pkg::ST_ACCEPTED;
            if (good_cnt > lim) begin
                // median path; only here does a good reading clear the fail count
                fail_cnt    = '0;
                win_hist[0] = win_hist[1];
                win_hist[1] = win_hist[2];
                win_hist[2] = scaled[tqr_pkg::TEMP_W-1:0];
                held_temp   = median3(win_hist[0], win_hist[1], win_hist[2]);
                n_median++;
            end else begin
                // still filling: store in turn and pass through unchanged
                win_hist[good_cnt] = scaled[tqr_pkg::TEMP_W-1:0];
                held_temp          = scaled[tqr_pkg::TEMP_W-1:0];
                good_cnt           = good_cnt + 1'b1;
            end
            fault_now = 1'b0;
        end
        if (fault_now && !was_fault) n_fault_rise++;
        res.temp  = held_temp;
        res.fault = fault_now;
        return res;
    endfunction

    // Driver: present the next request at the falling edge; hold it while stalled.
    always @(negedge i_clk) begin
        t_reading nxt;
        logic     offer;
        offer = i_valid;
        if (!i_valid || req_taken) begin
            offer = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (reading_queue.size() > 0) begin
                if (tx_idle_on && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(1, 19) - 1;
                end else begin
                    nxt = reading_queue.pop_front();
                    i_read_ok  <= nxt.read_ok;
                    i_raw_word <= nxt.raw;
                    offer = 1'b1;
                end
            end
        end
        i_valid <= offer;
    end

    // Receiver: random stall bursts, plus a long hold on request of the sequence.
    always @(negedge i_clk) begin
        if (rx_hold == 0 && hold_served != hold_asks) begin
            rx_hold = LONG_HOLD;
            hold_served++;
        end
        if (rx_hold > 0) begin
            rx_hold--;
        end else if (rx_burst > 0) begin
            rx_burst--;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_burst = $urandom_range(1, 19);
        end
        i_stall <= (rx_hold > 0) || (rx_burst > 0);
    end

    // Monitor: check results first, then apply register writes, then predict
    // for the request taken at this edge.
    always @(posedge i_clk) begin
        t_qual_result want;
        t_reading     taken;
        req_taken <= i_valid && !o_stall;
        if (o_valid && !i_stall) begin
            results_seen++;
            if (predicted_results.size() == 0) begin
                report_mismatch("result with nothing predicted, temperature",
                                o_temperature, 0);
            end else begin
                want = predicted_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_temperature !== want.temp)
                    report_mismatch("temperature", o_temperature, want.temp);
                if (o_sensor_fault !== want.fault)
                    report_mismatch("sensor_fault", o_sensor_fault, want.fault);
            end
        end
        if (i_cfg_valid && o_cfg_ready) begin
            case (tqr_pkg::t_cfg_index'(i_cfg_index))
                tqr_pkg::CFG_FAIL_LIMIT: cfg_fail_limit = i_cfg_data;
                tqr_pkg::CFG_OK_LIMIT:   cfg_ok_limit   = i_cfg_data[tqr_pkg::OKL_W-1:0];
                default: ;
            endcase
            n_cfg_writes++;
        end
        if (i_valid && !o_stall) begin
            taken.read_ok = i_read_ok;
            taken.raw     = i_raw_word;
            predicted_results.push_back(qualify_reading(taken));
        end
    end

    // Watchdog: end the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("temperature_reading_qualifier_unit_test: errors");
                $finish;
            end
        end
    end

    task automatic push_reading(input logic ok, input logic [tqr_pkg::RAW_W-1:0] raw);
        t_reading r;
        r.read_ok = ok;
        r.raw     = raw;
        reading_queue.push_back(r);
        items_queued++;
    endtask

    // Good attempt: full-range words, a plausible band, near-tie clusters, extremes.
    task automatic push_good();
        int unsigned sel;
        logic [tqr_pkg::RAW_W-1:0] raw;
        sel = $urandom_range(0, 9);
        if (sel < 4)      raw = tqr_pkg::RAW_W'($urandom);
        else if (sel < 7) raw = tqr_pkg::RAW_W'(int'($urandom_range(0, 1600)) - 400);
        else if (sel < 9) raw = tqr_pkg::RAW_W'(8 * $urandom_range(1, 4) + $urandom_range(0, 7));
        else begin
            case ($urandom_range(0, 3))
                0: raw = 16'h8000;
                1: raw = 16'h7FFF;
                2: raw = 16'h8007;
                default: raw = 16'h7FF8;
            endcase
        end
        push_reading(1'b1, raw);
    endtask

    // Failed attempt: bus failure with any word, or a word that decodes to 0 or 850.
    task automatic push_fail();
        case ($urandom_range(0, 2))
            0: push_reading(1'b0, tqr_pkg::RAW_W'($urandom));
            1: push_reading(1'b1, tqr_pkg::RAW_W'($urandom_range(0, 7)));
            default: push_reading(1'b1, tqr_pkg::RAW_W'(1360 + $urandom_range(0, 7)));
        endcase
    endtask

    // Mostly runs of good readings, broken by short failure runs and now and
    // then a long one that can reach the fault limit.
    task automatic queue_mixed(input int unsigned n);
        int unsigned start;
        int unsigned len;
        start = items_queued;
        while (items_queued - start < n) begin
            len = $urandom_range(1, 8);
            repeat (len) push_good();
            if ($urandom_range(0, 19) == 0) len = $urandom_range(5, 70);
            else                            len = $urandom_range(1, 3);
            repeat (len) push_fail();
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (results_seen != items_queued) @(negedge i_clk);
    endtask

    task automatic cfg_write(input tqr_pkg::t_cfg_index idx,
                             input logic [tqr_pkg::CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(input logic [tqr_pkg::FAIL_W-1:0] fl,
                              input logic [tqr_pkg::OKL_W-1:0] ol);
        cfg_write(tqr_pkg::CFG_FAIL_LIMIT, fl);
        // upper data bits are don't-care for the ok limit; fill them at random
        cfg_write(tqr_pkg::CFG_OK_LIMIT,
                  {(tqr_pkg::CFG_DATA_W - tqr_pkg::OKL_W)'($urandom), ol});
    endtask

    task automatic run_phase(input logic [tqr_pkg::FAIL_W-1:0] fl,
                             input logic [tqr_pkg::OKL_W-1:0] ol,
                             input int unsigned n);
        set_limits(fl, ol);
        queue_mixed(n);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: read failures, both reject points and
        // their neighbors, decode extremes, the fill, and medians with ties.
        push_reading(1'b0, 16'h7FFF);
        push_reading(1'b0, 16'h8000);
        push_reading(1'b1, 16'd0);
        push_reading(1'b1, 16'd7);
        push_reading(1'b1, 16'd1360);
        push_reading(1'b1, 16'd1367);
        push_reading(1'b1, 16'h8000);
        push_reading(1'b1, 16'h7FFF);
        push_reading(1'b1, 16'hFFFF);
        push_reading(1'b1, 16'd8);
        push_reading(1'b1, 16'd1359);
        push_reading(1'b1, 16'd1368);
        push_reading(1'b1, 16'hFFF8);
        push_reading(1'b1, 16'hFFF7);
        push_reading(1'b0, 16'h0000);
        push_reading(1'b1, 16'd1000);
        push_reading(1'b1, 16'd1000);
        push_reading(1'b1, 16'hFFF8);
        push_reading(1'b1, 16'd1001);
        push_reading(1'b1, 16'h5555);
        push_reading(1'b1, 16'hAAAA);
        push_reading(1'b0, 16'hFFFF);
        // leave the window part-filled so the next phase lowers the limit mid-fill
        push_reading(1'b1, 16'd16);

        // Strictest settings: every failure raises the fault, medians from the start.
        run_phase(8'd0, 2'd0, 15);

        // Widest fail limit with the out-of-range ok limit: drive the fail count
        // through its wrap, where no new fault may be raised.
        set_limits(8'd255, 2'd3);
        repeat (258) push_fail();
        queue_mixed(10);

        run_phase(8'd1, 2'd1, 15);
        run_phase(8'd3, 2'd2, 15);

        // Pressure: receiver holds off while the sender keeps offering requests.
        set_limits(tqr_pkg::FAIL_LIMIT_RST, tqr_pkg::OK_LIMIT_RST);
        wait_idle();
        tx_idle_on = 1'b0;
        hold_asks++;
        queue_mixed(35);
        wait_idle();
        tx_idle_on = 1'b1;

        run_phase(tqr_pkg::FAIL_W'($urandom_range(0, 255)),
                  tqr_pkg::OKL_W'($urandom_range(0, 3)), 15);
        run_phase(tqr_pkg::FAIL_W'($urandom_range(0, 255)),
                  tqr_pkg::OKL_W'($urandom_range(0, 3)), 15);
        run_phase(8'd255, 2'd0, 15);

        // Last stretch runs back to back on both sides.
        set_limits(8'd2, 2'd3);
        wait_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // let any idle burst still in progress run out first
        while (rx_burst != 0 || tx_gap != 0) @(negedge i_clk);
        queue_mixed(25);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predicted_results.size() != 0)
            report_mismatch("predictions left over", predicted_results.size(), 0);

        $display("covered %0d read attempts and %0d results across %0d register writes,",
                 items_queued, results_seen, n_cfg_writes);
        $display("with %0d median outputs, %0d fault raises and one long receiver hold",
                 n_median, n_fault_rise);
        if (err_count == 0) begin
            $display("temperature_reading_qualifier_unit_test: clean");
        end else begin
            $display("temperature_reading_qualifier_unit_test: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/tqr_pkg.sv
rtl/tqr_decode.sv
rtl/tqr_median.sv
rtl/temperature_reading_qualifier_unit.sv
bench/temperature_reading_qualifier_unit_test.sv
